// ===== design/animation_frame_sequencer_core_defines.svh =====
// Assertion macros shared by the frame sequencer modules.
// No dependencies; included by the files that carry assertions.
`ifndef ANIMATION_FRAME_SEQUENCER_CORE_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define AFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/afs_pkg.sv =====
// Types, constants and microcode codes of the animation frame sequencer.
// No dependencies; imported by every module of the block.
package afs_pkg;

    localparam int MAX_FRAMES     = 256;
    localparam int DEFAULT_PERIOD = 100;
    localparam int PC_W           = 4;

    localparam logic [8:0]  FRAMES_CAP = 9'(MAX_FRAMES);
    localparam logic [15:0] PERIOD_DEF = 16'(DEFAULT_PERIOD);

    typedef struct packed {
        logic        req_type;
        logic [15:0] dt_ms;
        logic        force_req;
        logic [7:0]  clip_id;
        logic [8:0]  clip_frames;
        logic [15:0] clip_frame_ms;
        logic        clip_loop;
        logic        clip_pingpong;
    } t_afs_in;

    typedef struct packed {
        logic [7:0] frame_now;
        logic       going_back;
        logic       is_playing;
        logic       is_finished;
    } t_afs_out;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_RESUME = 3'd2,
        OP_SINGLE = 3'd3,
        OP_ADD    = 3'd4,
        OP_STEP   = 3'd5,
        OP_EMIT   = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER  = 4'd0,
        C_ALWAYS = 4'd1,
        C_NOACC  = 4'd2,
        C_TICK   = 4'd3,
        C_ZERO   = 4'd4,
        C_RESUME = 4'd5,
        C_SKIP   = 4'd6,
        C_MULTI  = 4'd7,
        C_LT     = 4'd8,
        C_BUSY   = 4'd9
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic tick;
        logic zero;
        logic resume;
        logic skip;
        logic single;
        logic lt;
    } t_flags;

    // program addresses
    localparam logic [PC_W-1:0] ST_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] ST_TICK   = 4'd5;
    localparam logic [PC_W-1:0] ST_ADD    = 4'd8;
    localparam logic [PC_W-1:0] ST_LOOP   = 4'd9;
    localparam logic [PC_W-1:0] ST_RESUME = 4'd11;
    localparam logic [PC_W-1:0] ST_EMIT   = 4'd12;

endpackage

// ===== design/animation_frame_sequencer_core.sv =====
// Accept to result register: a play beat loads or resumes its clip or is ignored;
// a tick goes straight to the result with no clip or paused, takes one step on a
// single-frame clip, and otherwise adds dt, then subtracts one period per pass
// (frame steps, and remainder steps after a clip ends). Throughput: one beat at a
// time, the next once the result is registered; a result waits on a stalled one.
// Reset: synchronous active low; clears clip, position, timer, flags and output valid.
`include "animation_frame_sequencer_core_defines.svh"
module animation_frame_sequencer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  afs_pkg::t_afs_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output afs_pkg::t_afs_out o_data
);
    import afs_pkg::*;

    t_ctrl    w_ctrl;
    t_flags   w_flags;
    t_afs_out w_state;
    logic     w_idle;
    logic     w_accept;
    logic     w_out_busy;
    logic     w_emit;
    logic     r_out_valid;
    t_afs_out r_out;

    assign o_stall    = !w_idle;
    assign w_accept   = i_valid && w_idle;
    assign w_out_busy = r_out_valid && i_stall;
    assign w_emit     = (w_ctrl.op == OP_EMIT) && !w_out_busy;

    afs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_out_busy (w_out_busy),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl),
        .o_idle     (w_idle)
    );

    afs_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_req   (i_data),
        .i_op    (w_ctrl.op),
        .o_flags (w_flags),
        .o_state (w_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_state;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `AFS_ASSERT_NXT(a_accept_leaves_wait, i_clk, i_rst_n, w_accept, !w_idle, "beat taken but sequencer idle")
    `AFS_ASSERT_IMP(a_emit_into_free_slot, i_clk, i_rst_n, w_emit, !r_out_valid || !i_stall, "result overwrites pending beat")

endmodule

// ===== design/afs_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump condition select.
// Depends on afs_pkg.
module afs_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_out_busy,
    input  afs_pkg::t_flags  i_flags,
    output afs_pkg::t_ctrl   o_ctrl,
    output logic             o_idle
);
    import afs_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;
    logic            w_take;

    function automatic t_ctrl rom_word(input logic [PC_W-1:0] addr);
        t_ctrl w;
        case (addr)
            4'd0:    w = '{op: OP_NONE,   cond: C_NOACC,  target: ST_WAIT};
            4'd1:    w = '{op: OP_NONE,   cond: C_TICK,   target: ST_TICK};
            4'd2:    w = '{op: OP_NONE,   cond: C_ZERO,   target: ST_EMIT};
            4'd3:    w = '{op: OP_NONE,   cond: C_RESUME, target: ST_RESUME};
            4'd4:    w = '{op: OP_LOAD,   cond: C_ALWAYS, target: ST_EMIT};
            4'd5:    w = '{op: OP_NONE,   cond: C_SKIP,   target: ST_EMIT};
            4'd6:    w = '{op: OP_NONE,   cond: C_MULTI,  target: ST_ADD};
            4'd7:    w = '{op: OP_SINGLE, cond: C_ALWAYS, target: ST_EMIT};
            4'd8:    w = '{op: OP_ADD,    cond: C_NEVER,  target: ST_WAIT};
            4'd9:    w = '{op: OP_NONE,   cond: C_LT,     target: ST_EMIT};
            4'd10:   w = '{op: OP_STEP,   cond: C_ALWAYS, target: ST_LOOP};
            4'd11:   w = '{op: OP_RESUME, cond: C_ALWAYS, target: ST_EMIT};
            4'd12:   w = '{op: OP_EMIT,   cond: C_BUSY,   target: ST_EMIT};
            default: w = '{op: OP_NONE,   cond: C_ALWAYS, target: ST_WAIT};
        endcase
        return w;
    endfunction

    always_comb begin
        w_ctrl = rom_word(r_pc);
        case (w_ctrl.cond)
            C_NEVER:  w_take = 1'b0;
            C_ALWAYS: w_take = 1'b1;
            C_NOACC:  w_take = !i_accept;
            C_TICK:   w_take = i_flags.tick;
            C_ZERO:   w_take = i_flags.zero;
            C_RESUME: w_take = i_flags.resume;
            C_SKIP:   w_take = i_flags.skip;
            C_MULTI:  w_take = !i_flags.single;
            C_LT:     w_take = i_flags.lt;
            C_BUSY:   w_take = i_out_busy;
            default:  w_take = 1'b1;
        endcase
        n_pc = w_take ? w_ctrl.target : PC_W'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_idle = (r_pc == ST_WAIT);

endmodule

// ===== design/afs_dp.sv =====
// Datapath: request latch, loaded clip, frame position, direction and timer.
// Depends on afs_pkg and the assertion macro header.
`include "animation_frame_sequencer_core_defines.svh"
module afs_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  afs_pkg::t_afs_in  i_req,
    input  afs_pkg::t_op      i_op,
    output afs_pkg::t_flags   o_flags,
    output afs_pkg::t_afs_out o_state
);
    import afs_pkg::*;

    t_afs_in     r_in;
    logic        r_loaded;
    logic [7:0]  r_id;
    logic [8:0]  r_frames;
    logic [15:0] r_period;
    logic        r_loop;
    logic        r_bounce;
    logic [7:0]  r_pos;
    logic        r_back;
    logic [16:0] r_elapsed;
    logic        r_run;
    logic        r_done;
    logic        r_drain;

    logic [15:0] w_period;
    logic [8:0]  w_fwd;
    logic [7:0]  n_pos;
    logic        n_back;
    logic        w_ended;

    assign w_period = (r_period == 16'd0) ? PERIOD_DEF : r_period;
    assign w_fwd    = {1'b0, r_pos} + 9'd1;

    always_comb begin
        n_pos   = r_pos;
        n_back  = r_back;
        w_ended = 1'b0;
        if (!r_back) begin
            if (w_fwd >= r_frames) begin
                if (r_bounce) begin
                    n_back = 1'b1;
                    n_pos  = 8'(r_frames - 9'd2);
                end else if (r_loop) begin
                    n_pos = 8'd0;
                end else begin
                    n_pos   = 8'(r_frames - 9'd1);
                    w_ended = 1'b1;
                end
            end else begin
                n_pos = w_fwd[7:0];
            end
        end else if (r_pos == 8'd0) begin
            n_back = 1'b0;
            n_pos  = 8'd1;
        end else begin
            n_pos = r_pos - 8'd1;
        end
        if (r_bounce && !r_loop && n_back && n_pos == 8'd0) begin
            w_ended = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= 1'b0;
            r_id      <= 8'd0;
            r_frames  <= 9'd0;
            r_period  <= 16'd0;
            r_loop    <= 1'b0;
            r_bounce  <= 1'b0;
            r_pos     <= 8'd0;
            r_back    <= 1'b0;
            r_elapsed <= 17'd0;
            r_run     <= 1'b0;
            r_done    <= 1'b0;
            r_drain   <= 1'b0;
        end else begin
            case (i_op)
                OP_LOAD: begin
                    r_loaded  <= 1'b1;
                    r_id      <= r_in.clip_id;
                    r_frames  <= (r_in.clip_frames > FRAMES_CAP) ? FRAMES_CAP
                                                                 : r_in.clip_frames;
                    r_period  <= r_in.clip_frame_ms;
                    r_loop    <= r_in.clip_loop;
                    r_bounce  <= r_in.clip_pingpong;
                    r_pos     <= 8'd0;
                    r_back    <= 1'b0;
                    r_elapsed <= 17'd0;
                    r_done    <= 1'b0;
                    r_run     <= 1'b1;
                end
                OP_RESUME: r_run <= 1'b1;
                OP_SINGLE: r_done <= !r_loop;
                OP_ADD: begin
                    r_elapsed <= 17'(r_elapsed + {1'b0, r_in.dt_ms});
                    r_drain   <= 1'b0;
                end
                OP_STEP: begin
                    r_elapsed <= r_elapsed - {1'b0, w_period};
                    // once ended, keep subtracting to reduce the remainder
                    if (!r_drain) begin
                        r_pos  <= n_pos;
                        r_back <= n_back;
                        if (w_ended) begin
                            r_done  <= 1'b1;
                            r_run   <= 1'b0;
                            r_drain <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_flags.tick   = !r_in.req_type;
    assign o_flags.zero   = (r_in.clip_frames == 9'd0);
    assign o_flags.resume = !r_in.force_req && r_loaded && (r_in.clip_id == r_id);
    assign o_flags.skip   = !r_loaded || !r_run;
    assign o_flags.single = (r_frames <= 9'd1);
    assign o_flags.lt     = (r_elapsed < {1'b0, w_period});

    assign o_state.frame_now   = r_pos;
    assign o_state.going_back  = r_back;
    assign o_state.is_playing  = r_run;
    assign o_state.is_finished = r_done;

    `AFS_ASSERT_IMP(a_pos_in_clip, i_clk, i_rst_n, r_loaded, {1'b0, r_pos} < r_frames, "frame beyond clip")
    `AFS_ASSERT_IMP(a_back_needs_bounce, i_clk, i_rst_n, r_back, r_bounce, "backward without ping-pong")

endmodule
